@@ hw/rtl/fgs_pkg.sv @@
package fgs_pkg;

    localparam int DEF_MAX_FRONTIERS = 64;
    localparam int DEF_MAX_VISITED   = 32;
    localparam int DEF_COORD_BITS    = 24;

    localparam int SIZE_BITS   = 16;
    localparam int MAXC_BITS   = 7;
    localparam int DW_BITS     = 16;
    localparam int SW_BITS     = 24;
    localparam int RAD_BITS    = 16;
    localparam int D2_BITS     = 64;
    localparam int ROOT_BITS   = D2_BITS / 2;
    localparam int COST_BITS   = 32;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;
    localparam int STEP_BITS   = 5;

    localparam logic [SIZE_BITS-1:0] RST_MIN_SIZE = 16'd8;
    localparam logic [MAXC_BITS-1:0] RST_MAX_CAND = 7'd8;
    localparam logic [DW_BITS-1:0]   RST_DIST_W   = 16'd256;
    localparam logic [SW_BITS-1:0]   RST_SIZE_W   = 24'd1000;
    localparam logic [RAD_BITS-1:0]  RST_RADIUS   = 16'd500;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_MARK   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_SELECT = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_MIN_SIZE = 3'd0,
        REG_MAX_CAND = 3'd1,
        REG_DIST_W   = 3'd2,
        REG_SIZE_W   = 3'd3,
        REG_RADIUS   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_BITS-1:0] min_size;
        logic [MAXC_BITS-1:0] max_cand;
        logic [DW_BITS-1:0]   dist_w;
        logic [SW_BITS-1:0]   size_w;
        logic [RAD_BITS-1:0]  radius;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_F_RD, S_F_LAT, S_V_RD, S_V_SQ, S_V_CMP, S_CHECK,
        S_R_I, S_R_LAT, S_R_J_RD, S_R_J_CMP, S_R_END,
        S_C_SQ, S_C_INIT, S_C_ITER, S_C_MUL, S_C_UPD, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MARK, OP_CLEAR, OP_START,
        OP_F_RD, OP_F_LAT, OP_V_RD, OP_V_SQ, OP_V_CMP, OP_CHECK,
        OP_R_I, OP_R_LAT, OP_R_J_RD, OP_R_J_CMP, OP_R_END,
        OP_C_SQ, OP_C_INIT, OP_C_ITER, OP_C_MUL, OP_C_UPD, OP_DONE
    } t_op;

    typedef struct packed {
        logic f_empty;
        logic v_empty;
        logic i_last;
        logic used_i;
        logic near_hit;
        logic v_last;
        logic j_last;
        logic rank_ge_k;
        logic iter_done;
    } t_status;

endpackage

@@ hw/rtl/fgs_ram.sv @@
module fgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fgs_ctrl.sv @@
module fgs_ctrl
    import fgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [1:0] i_action,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_action action;
    logic    accept;

    assign action     = t_action'(i_action);
    assign o_in_ready = (r_state == S_IDLE) && !(action == ACT_SELECT && r_out_valid);
    assign accept     = i_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && action == ACT_SELECT) begin
                    n_state = i_status.f_empty ? S_DONE : S_F_RD;
                end
            end
            S_F_RD:  n_state = S_F_LAT;
            S_F_LAT: begin
                if (i_status.v_empty) begin
                    n_state = i_status.i_last ? S_CHECK : S_F_RD;
                end else begin
                    n_state = S_V_RD;
                end
            end
            S_V_RD:  n_state = S_V_SQ;
            S_V_SQ:  n_state = S_V_CMP;
            S_V_CMP: begin
                if (i_status.near_hit || i_status.v_last) begin
                    n_state = i_status.i_last ? S_CHECK : S_F_RD;
                end else begin
                    n_state = S_V_RD;
                end
            end
            S_CHECK: n_state = S_R_I;
            S_R_I: begin
                if (!i_status.used_i) begin
                    n_state = i_status.i_last ? S_DONE : S_R_I;
                end else begin
                    n_state = S_R_LAT;
                end
            end
            S_R_LAT:   n_state = S_R_J_RD;
            S_R_J_RD:  n_state = S_R_J_CMP;
            S_R_J_CMP: n_state = i_status.j_last ? S_R_END : S_R_J_RD;
            S_R_END: begin
                if (i_status.rank_ge_k) begin
                    n_state = i_status.i_last ? S_DONE : S_R_I;
                end else begin
                    n_state = S_C_SQ;
                end
            end
            S_C_SQ:   n_state = S_C_INIT;
            S_C_INIT: n_state = S_C_ITER;
            S_C_ITER: n_state = i_status.iter_done ? S_C_MUL : S_C_ITER;
            S_C_MUL:  n_state = S_C_UPD;
            S_C_UPD:  n_state = i_status.i_last ? S_DONE : S_R_I;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (action)
                        ACT_LOAD:   o_op = OP_LOAD;
                        ACT_MARK:   o_op = OP_MARK;
                        ACT_CLEAR:  o_op = OP_CLEAR;
                        ACT_SELECT: o_op = OP_START;
                        default:    o_op = OP_NONE;
                    endcase
                end
            end
            S_F_RD:    o_op = OP_F_RD;
            S_F_LAT:   o_op = OP_F_LAT;
            S_V_RD:    o_op = OP_V_RD;
            S_V_SQ:    o_op = OP_V_SQ;
            S_V_CMP:   o_op = OP_V_CMP;
            S_CHECK:   o_op = OP_CHECK;
            S_R_I:     o_op = OP_R_I;
            S_R_LAT:   o_op = OP_R_LAT;
            S_R_J_RD:  o_op = OP_R_J_RD;
            S_R_J_CMP: o_op = OP_R_J_CMP;
            S_R_END:   o_op = OP_R_END;
            S_C_SQ:    o_op = OP_C_SQ;
            S_C_INIT:  o_op = OP_C_INIT;
            S_C_ITER:  o_op = OP_C_ITER;
            S_C_MUL:   o_op = OP_C_MUL;
            S_C_UPD:   o_op = OP_C_UPD;
            S_DONE:    o_op = OP_DONE;
            default:   o_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/fgs_dp.sv @@
module fgs_dp
    import fgs_pkg::*;
#(
    parameter int MAX_FRONTIERS = DEF_MAX_FRONTIERS,
    parameter int MAX_VISITED   = DEF_MAX_VISITED,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_op                   i_op,
    input  t_cfg                  i_cfg,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [SIZE_BITS-1:0]  i_cell_count,
    input  logic                  i_new_set,
    output t_status               o_status,
    output logic                  o_found,
    output logic [COORD_BITS-1:0] o_goal_x,
    output logic [COORD_BITS-1:0] o_goal_y,
    output logic [SIZE_BITS-1:0]  o_goal_size,
    output logic                  o_history_cleared
);

    localparam int CB  = COORD_BITS;
    localparam int IW  = $clog2(MAX_FRONTIERS);
    localparam int CW  = $clog2(MAX_FRONTIERS + 1);
    localparam int VIW = (MAX_VISITED > 1) ? $clog2(MAX_VISITED) : 1;
    localparam int VCW = $clog2(MAX_VISITED + 1);
    localparam int FW  = 2 * CB + SIZE_BITS;
    localparam int VW  = 2 * CB;
    localparam int PW  = DW_BITS + ROOT_BITS;

    function automatic logic [D2_BITS-1:0] abs_diff(input logic [CB-1:0] a,
                                                    input logic [CB-1:0] b);
        logic signed [CB:0] d;
        logic [CB:0]        m;
        d = signed'({a[CB-1], a}) - signed'({b[CB-1], b});
        m = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
        return D2_BITS'(m);
    endfunction

    // counters and flags
    logic [CW-1:0]  r_fcount;
    logic [VCW-1:0] r_vcount;
    logic [VIW-1:0] r_wp;
    logic [IW-1:0]  r_i, r_fj;
    logic [VIW-1:0] r_vj;
    logic [MAX_FRONTIERS-1:0] r_used;
    logic           r_any, r_have, r_cleared;
    logic [CW-1:0]  r_rank, r_best_rank;

    // payload
    logic [CB-1:0]        r_rx, r_ry, r_fx, r_fy, r_bx, r_by;
    logic [SIZE_BITS-1:0] r_fs, r_bs;
    logic [D2_BITS-1:0]   r_sx, r_sy, r_rad;
    logic                 r_sat;
    logic [ROOT_BITS+2:0] r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [SW_BITS-1:0]   r_dq;
    logic [SIZE_BITS:0]   r_drem;
    logic [STEP_BITS-1:0] r_step;
    logic [PW-1:0]        r_prod;
    logic [COST_BITS-1:0] r_low_cost;
    logic                 r_found, r_hc;
    logic [CB-1:0]        r_gx, r_gy;
    logic [SIZE_BITS-1:0] r_gs;

    // memories
    logic          f_we, f_re, v_we, v_re;
    logic [IW-1:0] f_waddr, f_raddr;
    logic [FW-1:0] f_rdata;
    logic [VW-1:0] v_rdata;

    logic [CW-1:0]  fcount_eff;
    logic           load_ok;
    logic [CB-1:0]  rd_x, rd_y, vd_x, vd_y, bx, by;
    logic [SIZE_BITS-1:0] rd_s;
    logic [D2_BITS-1:0]   dx, dy;
    logic [D2_BITS:0]     sum65;
    logic [D2_BITS-1:0]   d2;
    logic [2*RAD_BITS-1:0] r2;
    logic [ROOT_BITS+2:0] rem_t, trial;
    logic [SIZE_BITS:0]   drem_t;
    logic [COST_BITS+8:0] c41;
    logic [COST_BITS-1:0] cost;
    logic [MAXC_BITS-1:0] k_eff;
    logic                 better, rank_hit;

    assign fcount_eff = i_new_set ? '0 : r_fcount;
    assign load_ok    = (i_cell_count >= i_cfg.min_size)
                        && (fcount_eff < CW'(MAX_FRONTIERS));

    assign f_we    = (i_op == OP_LOAD) && load_ok;
    assign f_waddr = IW'(fcount_eff);
    assign f_re    = (i_op == OP_F_RD) || (i_op == OP_R_I) || (i_op == OP_R_J_RD);
    assign f_raddr = (i_op == OP_R_J_RD) ? r_fj : r_i;
    assign v_we    = (i_op == OP_MARK);
    assign v_re    = (i_op == OP_V_RD);

    fgs_ram #(.WIDTH(FW), .DEPTH(MAX_FRONTIERS)) u_fgs_fram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata ({i_pos_x, i_pos_y, i_cell_count}),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    fgs_ram #(.WIDTH(VW), .DEPTH(MAX_VISITED)) u_fgs_vram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_wp),
        .i_wdata ({i_pos_x, i_pos_y}),
        .i_re    (v_re),
        .i_raddr (r_vj),
        .o_rdata (v_rdata)
    );

    assign rd_x = f_rdata[FW-1 -: CB];
    assign rd_y = f_rdata[SIZE_BITS +: CB];
    assign rd_s = f_rdata[SIZE_BITS-1:0];
    assign vd_x = v_rdata[VW-1 -: CB];
    assign vd_y = v_rdata[CB-1:0];

    // visited point or robot, against the latched frontier
    assign bx = (i_op == OP_V_SQ) ? vd_x : r_rx;
    assign by = (i_op == OP_V_SQ) ? vd_y : r_ry;
    assign dx = abs_diff(r_fx, bx);
    assign dy = abs_diff(r_fy, by);

    assign sum65 = {1'b0, r_sx} + {1'b0, r_sy};
    assign d2    = (r_sat || sum65[D2_BITS]) ? '1 : sum65[D2_BITS-1:0];
    assign r2    = i_cfg.radius * i_cfg.radius;

    assign rem_t = {r_rem[ROOT_BITS:0], r_rad[D2_BITS-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign drem_t = {r_drem[SIZE_BITS-1:0], r_dq[SW_BITS-1]};

    assign c41  = (COST_BITS+9)'(r_prod[PW-1:8]) + (COST_BITS+9)'(r_dq);
    assign cost = (r_fs == '0 || |c41[COST_BITS+8:COST_BITS]) ? '1 : c41[COST_BITS-1:0];
    assign better = !r_have || (cost < r_low_cost)
                    || (cost == r_low_cost && r_rank < r_best_rank);

    assign k_eff = (i_cfg.max_cand == '0) ? MAXC_BITS'(1) : i_cfg.max_cand;
    assign rank_hit = r_used[r_fj] && (r_fj != r_i)
                      && ((rd_s > r_fs) || (rd_s == r_fs && r_fj < r_i));

    always_comb begin
        o_status.f_empty   = (r_fcount == '0);
        o_status.v_empty   = (r_vcount == '0);
        o_status.i_last    = (CW'(r_i) + CW'(1) == r_fcount);
        o_status.used_i    = r_used[r_i];
        o_status.near_hit  = (d2 < D2_BITS'(r2));
        o_status.v_last    = (VCW'(r_vj) + VCW'(1) == r_vcount);
        o_status.j_last    = (CW'(r_fj) + CW'(1) == r_fcount);
        o_status.rank_ge_k = (32'(r_rank) >= 32'(k_eff));
        o_status.iter_done = (r_step == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= '0;
            r_vcount <= '0;
            r_wp     <= '0;
        end else begin
            unique case (i_op)
                OP_LOAD: begin
                    r_fcount <= load_ok ? fcount_eff + CW'(1) : fcount_eff;
                end
                OP_MARK: begin
                    r_wp <= (r_wp == VIW'(MAX_VISITED - 1)) ? '0 : r_wp + VIW'(1);
                    if (r_vcount < VCW'(MAX_VISITED)) begin
                        r_vcount <= r_vcount + VCW'(1);
                    end
                end
                OP_CLEAR: begin
                    r_vcount <= '0;
                    r_wp     <= '0;
                end
                OP_CHECK: begin
                    if (!r_any) begin
                        r_vcount <= '0;
                        r_wp     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_START: begin
                r_rx      <= i_pos_x;
                r_ry      <= i_pos_y;
                r_i       <= '0;
                r_any     <= 1'b0;
                r_have    <= 1'b0;
                r_cleared <= 1'b0;
            end
            OP_F_LAT: begin
                r_fx <= rd_x;
                r_fy <= rd_y;
                r_fs <= rd_s;
                r_vj <= '0;
                if (o_status.v_empty) begin
                    r_used[r_i] <= 1'b1;
                    r_any       <= 1'b1;
                    r_i         <= r_i + IW'(1);
                end
            end
            OP_V_SQ, OP_C_SQ: begin
                r_sx  <= dx[ROOT_BITS-1:0] * dx[ROOT_BITS-1:0];
                r_sy  <= dy[ROOT_BITS-1:0] * dy[ROOT_BITS-1:0];
                r_sat <= |dx[D2_BITS-1:ROOT_BITS] || |dy[D2_BITS-1:ROOT_BITS];
            end
            OP_V_CMP: begin
                if (o_status.near_hit) begin
                    r_used[r_i] <= 1'b0;
                    r_i         <= r_i + IW'(1);
                end else if (o_status.v_last) begin
                    r_used[r_i] <= 1'b1;
                    r_any       <= 1'b1;
                    r_i         <= r_i + IW'(1);
                end else begin
                    r_vj <= r_vj + VIW'(1);
                end
            end
            OP_CHECK: begin
                r_i <= '0;
                if (!r_any) begin
                    r_used    <= '1;
                    r_cleared <= 1'b1;
                end
            end
            OP_R_I: begin
                if (!r_used[r_i]) begin
                    r_i <= r_i + IW'(1);
                end
            end
            OP_R_LAT: begin
                r_fx   <= rd_x;
                r_fy   <= rd_y;
                r_fs   <= rd_s;
                r_rank <= '0;
                r_fj   <= '0;
            end
            OP_R_J_CMP: begin
                if (rank_hit) begin
                    r_rank <= r_rank + CW'(1);
                end
                r_fj <= r_fj + IW'(1);
            end
            OP_R_END: begin
                if (o_status.rank_ge_k) begin
                    r_i <= r_i + IW'(1);
                end
            end
            OP_C_INIT: begin
                r_rad  <= d2;
                r_rem  <= '0;
                r_root <= '0;
                r_dq   <= i_cfg.size_w;
                r_drem <= '0;
                r_step <= '0;
            end
            OP_C_ITER: begin
                // one root bit per step; the quotient runs alongside
                r_rad <= {r_rad[D2_BITS-3:0], 2'b00};
                if (rem_t >= trial) begin
                    r_rem  <= rem_t - trial;
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_t;
                    r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                end
                if (r_step < STEP_BITS'(SW_BITS)) begin
                    if (drem_t >= {1'b0, r_fs}) begin
                        r_drem <= drem_t - {1'b0, r_fs};
                        r_dq   <= {r_dq[SW_BITS-2:0], 1'b1};
                    end else begin
                        r_drem <= drem_t;
                        r_dq   <= {r_dq[SW_BITS-2:0], 1'b0};
                    end
                end
                r_step <= r_step + STEP_BITS'(1);
            end
            OP_C_MUL: begin
                r_prod <= i_cfg.dist_w * r_root;
            end
            OP_C_UPD: begin
                if (better) begin
                    r_have      <= 1'b1;
                    r_low_cost  <= cost;
                    r_best_rank <= r_rank;
                    r_bx        <= r_fx;
                    r_by        <= r_fy;
                    r_bs        <= r_fs;
                end
                r_i <= r_i + IW'(1);
            end
            OP_DONE: begin
                r_found <= r_have;
                r_gx    <= r_have ? r_bx : '0;
                r_gy    <= r_have ? r_by : '0;
                r_gs    <= r_have ? r_bs : '0;
                r_hc    <= r_have && r_cleared;
            end
            default: ;
        endcase
    end

    assign o_found           = r_found;
    assign o_goal_x          = r_gx;
    assign o_goal_y          = r_gy;
    assign o_goal_size       = r_gs;
    assign o_history_cleared = r_hc;

endmodule

@@ hw/rtl/frontier_goal_selector.sv @@
// Load, mark visited and clear visited can arrive back to back.
// Select runs a visited test of every frontier against the visited points,
// then ranks the frontiers kept and scores each candidate.
// Scoring is bound by the 32-step square root and divider unit, one bit per cycle.
// Reset (synchronous, active low) empties both stores and restores the register defaults;
// no clearing pass is needed.
module frontier_goal_selector
    import fgs_pkg::*;
#(
    parameter int MAX_FRONTIERS = DEF_MAX_FRONTIERS,
    parameter int MAX_VISITED   = DEF_MAX_VISITED,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_action,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [SIZE_BITS-1:0]  i_cell_count,
    input  logic                  i_new_set,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_found,
    output logic [COORD_BITS-1:0] o_goal_x,
    output logic [COORD_BITS-1:0] o_goal_y,
    output logic [SIZE_BITS-1:0]  o_goal_size,
    output logic                  o_history_cleared,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    t_status  status;
    t_op      op;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_size <= RST_MIN_SIZE;
            r_cfg.max_cand <= RST_MAX_CAND;
            r_cfg.dist_w   <= RST_DIST_W;
            r_cfg.size_w   <= RST_SIZE_W;
            r_cfg.radius   <= RST_RADIUS;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_MIN_SIZE: r_cfg.min_size <= pwdata[SIZE_BITS-1:0];
                REG_MAX_CAND: r_cfg.max_cand <= pwdata[MAXC_BITS-1:0];
                REG_DIST_W:   r_cfg.dist_w   <= pwdata[DW_BITS-1:0];
                REG_SIZE_W:   r_cfg.size_w   <= pwdata[SW_BITS-1:0];
                REG_RADIUS:   r_cfg.radius   <= pwdata[RAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_SIZE: prdata = DATA_BITS'(r_cfg.min_size);
            REG_MAX_CAND: prdata = DATA_BITS'(r_cfg.max_cand);
            REG_DIST_W:   prdata = DATA_BITS'(r_cfg.dist_w);
            REG_SIZE_W:   prdata = DATA_BITS'(r_cfg.size_w);
            REG_RADIUS:   prdata = DATA_BITS'(r_cfg.radius);
            default:      prdata = '0;
        endcase
    end

    fgs_ctrl u_fgs_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_op        (op),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid)
    );

    fgs_dp #(
        .MAX_FRONTIERS (MAX_FRONTIERS),
        .MAX_VISITED   (MAX_VISITED),
        .COORD_BITS    (COORD_BITS)
    ) u_fgs_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .i_cfg             (r_cfg),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_cell_count      (i_cell_count),
        .i_new_set         (i_new_set),
        .o_status          (status),
        .o_found           (o_found),
        .o_goal_x          (o_goal_x),
        .o_goal_y          (o_goal_y),
        .o_goal_size       (o_goal_size),
        .o_history_cleared (o_history_cleared)
    );

endmodule

@@ hw/rtl/fgs_checker.sv @@
module fgs_checker
    import fgs_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [1:0]            i_action,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_found,
    input logic [COORD_BITS-1:0] o_goal_x,
    input logic [COORD_BITS-1:0] o_goal_y,
    input logic [SIZE_BITS-1:0]  o_goal_size,
    input logic                  o_history_cleared
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_goal_x) && $stable(o_goal_size))
        else $error("result changed while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_goal_x == '0 && o_goal_y == '0
                                && o_goal_size == '0 && !o_history_cleared)
        else $error("empty result carries data");

    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_action == ACT_SELECT |=> !o_ready)
        else $error("input taken during select");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind frontier_goal_selector fgs_checker #(.COORD_BITS(COORD_BITS)) u_fgs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_action          (i_action),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_found           (o_found),
    .o_goal_x          (o_goal_x),
    .o_goal_y          (o_goal_y),
    .o_goal_size       (o_goal_size),
    .o_history_cleared (o_history_cleared)
);

@@ tb/frontier_goal_selector_test.sv @@
`timescale 1ns / 100ps

module frontier_goal_selector_test;
    import fgs_pkg::*;

    localparam int NF         = DEF_MAX_FRONTIERS;
    localparam int NV         = DEF_MAX_VISITED;
    localparam int CB         = DEF_COORD_BITS;
    localparam int LIMIT      = 4000000;
    localparam int HOLD_LEN   = 3000;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 235;
    localparam longint unsigned COST_SAT = 64'hFFFF_FFFF;

    typedef struct {
        logic          found;
        logic [CB-1:0] gx;
        logic [CB-1:0] gy;
        logic [15:0]   gsize;
        logic          cleared;
    } t_goal;

    typedef struct {
        t_action       act;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [15:0]   cells;
        logic          ns;
        bit            none_found;
    } t_row;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_valid = 0;
    logic          o_ready;
    logic [1:0]    i_action = ACT_LOAD;
    logic [CB-1:0] i_pos_x = '0;
    logic [CB-1:0] i_pos_y = '0;
    logic [15:0]   i_cell_count = '0;
    logic          i_new_set = 0;
    logic          o_valid;
    logic          i_ready = 0;
    logic          o_found;
    logic [CB-1:0] o_goal_x;
    logic [CB-1:0] o_goal_y;
    logic [15:0]   o_goal_size;
    logic          o_history_cleared;
    logic          psel = 0;
    logic          penable = 0;
    logic          pwrite = 0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic          pready;

    frontier_goal_selector i_dut (.*);

    // predictor copy of the block
    longint          fr_x [NF];
    longint          fr_y [NF];
    int unsigned     fr_size [NF];
    int              fr_count = 0;
    longint          vis_x [NV];
    longint          vis_y [NV];
    int              vis_count = 0;
    int              vis_ptr = 0;
    longint unsigned cfg_min = RST_MIN_SIZE;
    longint unsigned cfg_maxc = RST_MAX_CAND;
    longint unsigned cfg_dw = RST_DIST_W;
    longint unsigned cfg_sw = RST_SIZE_W;
    longint unsigned cfg_rad = RST_RADIUS;

    t_goal goal_q [$];
    int    errors = 0;
    int    cycles = 0;
    bit    row_none_found = 0;
    bit    hold_req = 0;
    int    burst_left = 0;
    int    sent = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint unsigned dist2(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = (ax >= bx) ? ax - bx : bx - ax;
        dy = (ay >= by) ? ay - by : by - ay;
        return dx * dx + dy * dy;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic bit choose_goal(logic [1:0] act, longint px, longint py,
                                       int unsigned cells, bit ns, output t_goal g);
        bit              used [NF];
        int              used_n;
        int              rank;
        int              best;
        int              best_rank;
        longint unsigned k;
        longint unsigned r2;
        longint unsigned c;
        longint unsigned low_cost;
        bit              have;
        bit              cleared;
        g = '{default: '0};
        if (act == ACT_LOAD) begin
            if (ns) fr_count = 0;
            if (cells >= cfg_min && fr_count < NF) begin
                fr_x[fr_count] = px;
                fr_y[fr_count] = py;
                fr_size[fr_count] = cells;
                fr_count++;
            end
            return 0;
        end
        if (act == ACT_MARK) begin
            vis_x[vis_ptr] = px;
            vis_y[vis_ptr] = py;
            vis_ptr = (vis_ptr + 1) % NV;
            if (vis_count < NV) vis_count++;
            return 0;
        end
        if (act == ACT_CLEAR) begin
            vis_count = 0;
            vis_ptr = 0;
            return 0;
        end
        used_n = 0;
        r2 = cfg_rad * cfg_rad;
        for (int i = 0; i < fr_count; i++) begin
            used[i] = 1;
            for (int v = 0; v < vis_count; v++)
                if (dist2(fr_x[i], fr_y[i], vis_x[v], vis_y[v]) < r2) used[i] = 0;
            if (used[i]) used_n++;
        end
        cleared = 0;
        if (fr_count > 0 && used_n == 0) begin
            vis_count = 0;
            vis_ptr = 0;
            cleared = 1;
            for (int i = 0; i < fr_count; i++) used[i] = 1;
        end
        k = (cfg_maxc == 0) ? 1 : cfg_maxc;
        have = 0;
        best = 0;
        best_rank = 0;
        low_cost = 0;
        for (int i = 0; i < fr_count; i++) begin
            if (!used[i]) continue;
            rank = 0;
            for (int j = 0; j < fr_count; j++) begin
                if (!used[j] || j == i) continue;
                if (fr_size[j] > fr_size[i] || (fr_size[j] == fr_size[i] && j < i)) rank++;
            end
            if (rank >= k) continue;
            if (fr_size[i] == 0) begin
                c = COST_SAT;
            end else begin
                c = ((cfg_dw * floor_root(dist2(px, py, fr_x[i], fr_y[i]))) >> 8)
                    + cfg_sw / fr_size[i];
                if (c > COST_SAT) c = COST_SAT;
            end
            if (!have || c < low_cost || (c == low_cost && rank < best_rank)) begin
                have = 1;
                best = i;
                low_cost = c;
                best_rank = rank;
            end
        end
        if (have) begin
            g.found = 1;
            g.gx = fr_x[best][CB-1:0];
            g.gy = fr_y[best][CB-1:0];
            g.gsize = fr_size[best][15:0];
            g.cleared = cleared;
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_goal g;
        if (i_rst_n && i_valid && o_ready) begin
            if (choose_goal(i_action, longint'($signed(i_pos_x)), longint'($signed(i_pos_y)),
                            i_cell_count, i_new_set, g)) begin
                if (row_none_found) g = '{default: '0};
                goal_q.insert(goal_q.size(), g);
            end
        end
    end

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        $display("mismatch at cycle %0d: %s expected %h got %h", cycles, field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_goal e;
        if (i_rst_n && o_valid && i_ready) begin
            if (goal_q.size() == 0) begin
                report_mismatch("unexpected result, goal_x", 0, o_goal_x);
            end else begin
                e = goal_q.pop_front();
                if (o_found !== e.found) report_mismatch("found", e.found, o_found);
                if (o_goal_x !== e.gx) report_mismatch("goal_x", e.gx, o_goal_x);
                if (o_goal_y !== e.gy) report_mismatch("goal_y", e.gy, o_goal_y);
                if (o_goal_size !== e.gsize) report_mismatch("goal_size", e.gsize, o_goal_size);
                if (o_history_cleared !== e.cleared)
                    report_mismatch("history_cleared", e.cleared, o_history_cleared);
            end
        end
    end

    // receiver: stretches of full rate, light and heavy stalls, one long hold-off
    initial begin
        int seg;
        int mode;
        forever begin
            seg = $urandom_range(10, 200);
            mode = $urandom_range(0, 2);
            repeat (seg) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 0;
                    i_ready <= 0;
                    repeat (HOLD_LEN) @(negedge i_clk);
                end
                case (mode)
                    0: i_ready <= 1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic send_item(t_action act, logic [CB-1:0] x, logic [CB-1:0] y,
                             logic [15:0] cells, logic ns, bit none_found = 0);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_action <= act;
        i_pos_x <= x;
        i_pos_y <= y;
        i_cell_count <= cells;
        i_new_set <= ns;
        row_none_found = none_found;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        burst_left = 0;
        while (goal_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [DATA_BITS-1:0] val);
        @(negedge i_clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_MIN_SIZE: cfg_min = val[15:0];
            REG_MAX_CAND: cfg_maxc = val[6:0];
            REG_DIST_W:   cfg_dw = val[15:0];
            REG_SIZE_W:   cfg_sw = val[23:0];
            default:      cfg_rad = val[15:0];
        endcase
    endtask

    task automatic set_all(int mn, int mc, int dw, int sw, int rad);
        write_reg(REG_MIN_SIZE, mn);
        write_reg(REG_MAX_CAND, mc);
        write_reg(REG_DIST_W, dw);
        write_reg(REG_SIZE_W, sw);
        write_reg(REG_RADIUS, rad);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return CB'($urandom);
        return CB'($urandom_range(0, 40000) - 20000);
    endfunction

    function automatic logic [15:0] rand_cells();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom_range(0, 65535));
        if (r == 1) return 16'hFFFF;
        if (r == 2) return (cfg_min == 0) ? 16'd0 : 16'(cfg_min - 1);
        v = int'(cfg_min) + int'($urandom_range(0, 40));
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // one planning round: a frontier set, some visited marks, then a select
    task automatic play_round(bit big);
        logic [CB-1:0] lx [$];
        logic [CB-1:0] ly [$];
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        int nf;
        int nm;
        int p;
        nf = big ? $urandom_range(60, 70) : $urandom_range(0, 8);
        nm = big ? $urandom_range(30, 36) : $urandom_range(0, 5);
        for (int i = 0; i < nf; i++) begin
            x = rand_coord();
            y = rand_coord();
            lx.insert(lx.size(), x);
            ly.insert(ly.size(), y);
            send_item(ACT_LOAD, x, y, rand_cells(), (i == 0) && ($urandom_range(0, 3) != 0));
        end
        if ($urandom_range(0, 7) == 0)
            send_item(ACT_CLEAR, rand_coord(), rand_coord(), 16'($urandom), 1'b0);
        for (int i = 0; i < nm; i++) begin
            if (lx.size() > 0 && $urandom_range(0, 1)) begin
                p = $urandom_range(0, lx.size() - 1);
                x = CB'(lx[p] + $urandom_range(0, 600) - 300);
                y = CB'(ly[p] + $urandom_range(0, 600) - 300);
            end else begin
                x = rand_coord();
                y = rand_coord();
            end
            send_item(ACT_MARK, x, y, 16'($urandom), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 5) == 0)
            send_item(t_action'($urandom_range(0, 3)), CB'($urandom), CB'($urandom),
                      16'($urandom), 1'($urandom_range(0, 1)));
        send_item(ACT_SELECT, rand_coord(), rand_coord(), 16'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    initial begin
        t_row rows [13];
        int   phase_start;
        rows[0]  = '{ACT_SELECT, 24'd0, 24'd0, 16'd0, 1'b0, 1'b1};
        rows[1]  = '{ACT_LOAD, 24'h7FFFFF, 24'h800000, 16'hFFFF, 1'b1, 1'b0};
        rows[2]  = '{ACT_LOAD, 24'h800000, 24'h7FFFFF, 16'd8, 1'b0, 1'b0};
        rows[3]  = '{ACT_LOAD, 24'd100, 24'd100, 16'd7, 1'b0, 1'b0};
        rows[4]  = '{ACT_SELECT, 24'd0, 24'd0, 16'd0, 1'b0, 1'b0};
        rows[5]  = '{ACT_MARK, 24'h7FFFFF, 24'h800000, 16'd0, 1'b0, 1'b0};
        rows[6]  = '{ACT_SELECT, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b1, 1'b0};
        rows[7]  = '{ACT_MARK, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b1, 1'b0};
        rows[8]  = '{ACT_SELECT, 24'h800000, 24'h800000, 16'd0, 1'b0, 1'b0};
        rows[9]  = '{ACT_MARK, 24'h800000, 24'h7FFFFF, 16'd0, 1'b0, 1'b0};
        rows[10] = '{ACT_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b0};
        rows[11] = '{ACT_LOAD, 24'd5, 24'd5, 16'd3, 1'b1, 1'b0};
        rows[12] = '{ACT_SELECT, 24'd0, 24'd0, 16'd0, 1'b0, 1'b1};

        i_rst_n <= 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        foreach (rows[r])
            send_item(rows[r].act, rows[r].x, rows[r].y, rows[r].cells, rows[r].ns,
                      rows[r].none_found);
        drain();

        // hold the receiver off and keep offering selects until the input stalls
        send_item(ACT_LOAD, 24'd10, 24'd20, 16'd30, 1'b1);
        send_item(ACT_LOAD, 24'd900, 24'd20, 16'd12, 1'b0);
        hold_req = 1;
        repeat (6) send_item(ACT_SELECT, rand_coord(), rand_coord(), 16'd0, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                set_all(0, 0, 0, 0, 0);
            else if (ph == 1)
                set_all(65535, 127, 65535, 16777215, 65535);
            else if (ph == 2)
                set_all(0, 64, 256, 1000, 500);
            else if (ph == 3)
                set_all(1, 1, 65535, 0, 3000);
            else
                set_all($urandom_range(0, 20), $urandom_range(1, 10),
                        $urandom_range(0, 1024), $urandom_range(0, 100000),
                        $urandom_range(0, 3000));
            phase_start = sent;
            if (ph == 2 || ph == 5) play_round(1);
            while (sent - phase_start < PHASE_ITEMS) play_round(0);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (errors == 0 && goal_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/fgs_pkg.sv
hw/rtl/fgs_ram.sv
hw/rtl/fgs_ctrl.sv
hw/rtl/fgs_dp.sv
hw/rtl/frontier_goal_selector.sv
hw/rtl/fgs_checker.sv
tb/frontier_goal_selector_test.sv
